>>> src/egd_pkg.sv
// ----------------------------------------------------------------------------
// egd_pkg
// Types and constants for the exp-gauss-exp density pipeline.
// ----------------------------------------------------------------------------
package egd_pkg;

  localparam int FRAC_BITS = 16;

  localparam int SAMPLE_W = 24;
  localparam int INV_W    = 21;
  localparam int TAIL_W   = 20;
  localparam int DENS_W   = 17;
  localparam int REGION_W = 2;

  localparam int MAG_W = SAMPLE_W;
  localparam int T_W   = MAG_W + INV_W - FRAC_BITS;
  localparam int U_W   = T_W + 1;
  localparam int OPA_W = TAIL_W;
  localparam int SQ_W  = OPA_W + U_W;
  localparam int MF_W  = SQ_W - (FRAC_BITS + 1);

  // exponent magnitude limit 32.0, core |t| limit 8.0
  localparam int M_W         = FRAC_BITS + 5;
  localparam int CORE_T_BITS = FRAC_BITS + 3;

  // exp(-m) in Q30: m = n*ln2 + r
  localparam int Q_BITS    = 30;
  localparam int EXP_SHIFT = Q_BITS - FRAC_BITS;
  localparam int R_W       = Q_BITS;
  localparam int ACC_W     = Q_BITS + 1;
  localparam int X_W       = Q_BITS;
  localparam int N_W       = 6;
  localparam int M30_W     = M_W + EXP_SHIFT;

  localparam logic [R_W-1:0]   LN2_Q30 = 30'd744261118;
  localparam logic [ACC_W-1:0] ONE_Q30 = 31'h4000_0000;

  // floor(2^(32+EXP_SHIFT) / LN2_Q30); estimate of n is exact or one low
  localparam int               N_RECIP_W   = 17;
  localparam logic [N_RECIP_W-1:0] N_RECIP = 17'd94548;
  localparam int               N_RECIP_SHIFT = 32;
  localparam int               NP_W        = M_W + N_RECIP_W;

  localparam int SERIES_TERMS = 12;
  localparam int RECIP_W      = 32;

  // largest n whose shift still leaves a nonzero result in a 32-bit word
  localparam logic [N_W-1:0] N_MAX_SHIFT = N_W'(31 - EXP_SHIFT);

  localparam logic [REGION_W-1:0] REGION_LEFT  = 2'd0;
  localparam logic [REGION_W-1:0] REGION_CORE  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_RIGHT = 2'd2;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] CFG_CENTER    = 3'd0;
  localparam logic [2:0] CFG_INV_LEFT  = 3'd1;
  localparam logic [2:0] CFG_TAIL_LEFT = 3'd2;
  localparam logic [2:0] CFG_INV_RIGHT = 3'd3;
  localparam logic [2:0] CFG_TAIL_RIGHT = 3'd4;

  // payload carried through the series stages
  typedef struct packed {
    logic [R_W-1:0]      r;
    logic [N_W-1:0]      n;
    logic                zero;
    logic [REGION_W-1:0] region;
    logic [ACC_W-1:0]    acc;
  } egd_term_t;

  // floor((2^32-1)/k); estimate of x/k for x < 2^31 is exact or one low
  function automatic logic [RECIP_W-1:0] recip_k(input logic [3:0] k);
    logic [RECIP_W-1:0] v;
    case (k)
      4'd1:    v = 32'd4294967295;
      4'd2:    v = 32'd2147483647;
      4'd3:    v = 32'd1431655765;
      4'd4:    v = 32'd1073741823;
      4'd5:    v = 32'd858993459;
      4'd6:    v = 32'd715827882;
      4'd7:    v = 32'd613566756;
      4'd8:    v = 32'd536870911;
      4'd9:    v = 32'd477218588;
      4'd10:   v = 32'd429496729;
      4'd11:   v = 32'd390451572;
      4'd12:   v = 32'd357913941;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/egd_horner_step.sv
// ----------------------------------------------------------------------------
// egd_horner_step
// One series term acc = 1 - (r*acc)/k in Q30, three register stages.
// ----------------------------------------------------------------------------
module egd_horner_step import egd_pkg::*; #(
  parameter int DIVISOR = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld_in,
  input  egd_term_t term_in,
  output logic      vld_out,
  output egd_term_t term_out
);

  localparam logic [3:0]         KD = 4'(DIVISOR);
  localparam logic [RECIP_W-1:0] MK = recip_k(KD);
  localparam int                 QK_W = X_W + 4;

  logic [2:0] vld_r;

  egd_term_t a_r, b_r, c_r;
  logic [X_W-1:0] xa_r, xb_r, qb_r;

  logic [R_W+ACC_W-1:0]   prod_a;
  logic [X_W+RECIP_W-1:0] prod_b;
  logic [QK_W-1:0]        rem;
  logic [X_W-1:0]         q;
  egd_term_t              c_nxt;

  assign prod_a = (R_W+ACC_W)'(term_in.r) * (R_W+ACC_W)'(term_in.acc);
  assign prod_b = (X_W+RECIP_W)'(xa_r) * (X_W+RECIP_W)'(MK);

  always_comb begin
    rem = QK_W'(xb_r) - QK_W'(qb_r) * QK_W'(KD);
    q   = (rem >= QK_W'(KD)) ? qb_r + X_W'(1) : qb_r;
    c_nxt     = b_r;
    c_nxt.acc = ONE_Q30 - ACC_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= term_in;
    xa_r <= prod_a[Q_BITS +: X_W];
    b_r  <= a_r;
    xb_r <= xa_r;
    qb_r <= prod_b[RECIP_W +: X_W];
    c_r  <= c_nxt;
  end

  assign vld_out  = vld_r[2];
  assign term_out = c_r;

endmodule

>>> src/exp_gauss_exp_density.sv
// ----------------------------------------------------------------------------
// exp_gauss_exp_density
// Unnormalized Gaussian core with exponential tails, one sample per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Registers are written over the APB port (center, inv_width_left,
//   tail_left, inv_width_right, tail_right at byte offsets 0,4,8,12,16)
//   while no transaction is in flight. Reads return the stored values.
//   A sample is accepted on a clock edge with start high and busy low.
//   busy is low whenever reset is released, so a new sample may enter on
//   every cycle.
//   Each result (out_density, out_region) is presented for one cycle with
//   out_strobe high, in the order in which the samples were accepted.
//   Throughput is one sample per cycle. The pipeline holds the 7 front
//   stages (difference, scaling multiply, region decision, exponent
//   multiply, ln2 range reduction), 36 series stages (12 terms of 3 stages)
//   and the output register.
//   Synchronous reset clears all valid bits and restores register defaults;
//   in-flight samples are dropped. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module exp_gauss_exp_density import egd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_strobe,
  output logic [DENS_W-1:0]          out_density,
  output logic [REGION_W-1:0]        out_region,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int LATENCY = 44;

  // configuration
  logic [SAMPLE_W-1:0] center_r;
  logic [INV_W-1:0]    inv_left_r, inv_right_r;
  logic [TAIL_W-1:0]   tail_left_r, tail_right_r;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r     <= '0;
      inv_left_r   <= INV_W'(1) << FRAC_BITS;
      tail_left_r  <= TAIL_W'(1) << FRAC_BITS;
      inv_right_r  <= INV_W'(1) << FRAC_BITS;
      tail_right_r <= TAIL_W'(1) << FRAC_BITS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_CENTER:     center_r     <= pwdata[SAMPLE_W-1:0];
        CFG_INV_LEFT:   inv_left_r   <= pwdata[INV_W-1:0];
        CFG_TAIL_LEFT:  tail_left_r  <= pwdata[TAIL_W-1:0];
        CFG_INV_RIGHT:  inv_right_r  <= pwdata[INV_W-1:0];
        CFG_TAIL_RIGHT: tail_right_r <= pwdata[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_CENTER:     prdata = DATA_W'(center_r);
      CFG_INV_LEFT:   prdata = DATA_W'(inv_left_r);
      CFG_TAIL_LEFT:  prdata = DATA_W'(tail_left_r);
      CFG_INV_RIGHT:  prdata = DATA_W'(inv_right_r);
      CFG_TAIL_RIGHT: prdata = DATA_W'(tail_right_r);
      default:        prdata = '0;
    endcase
  end

  // the pipeline never stalls; only reset holds off a transaction
  assign busy = !rst_n;

  logic in_acc;
  assign in_acc = start && !busy;

  // stage 0: difference, magnitude, side select
  logic [SAMPLE_W:0]   diff;
  logic                left_nxt;
  logic [SAMPLE_W:0]   mag_full;
  logic [6:0]          vld_r;
  logic [MAG_W-1:0]    s0_mag_r;
  logic [INV_W-1:0]    s0_inv_r;
  logic [TAIL_W-1:0]   s0_a_r, s1_a_r;
  logic                s0_left_r, s1_left_r;

  assign diff     = {in_sample_value[SAMPLE_W-1], in_sample_value}
                  - {center_r[SAMPLE_W-1], center_r};
  assign left_nxt = diff[SAMPLE_W];
  assign mag_full = left_nxt ? -diff : diff;

  // stage 1: t = |d| * inv
  logic [MAG_W+INV_W-1:0] prod1;
  logic [T_W-1:0]         s1_t_r;
  assign prod1 = (MAG_W+INV_W)'(s0_mag_r) * (MAG_W+INV_W)'(s0_inv_r);

  // stage 2: region decision and multiplier operands
  logic                tail;
  logic [U_W-1:0]      u;
  logic [OPA_W-1:0]    s2_opa_r;
  logic [U_W-1:0]      s2_opb_r;
  logic                s2_sat_r;
  logic [REGION_W-1:0] region_nxt;
  logic [REGION_W-1:0] s2_region_r, s3_region_r, s4_region_r, s5_region_r, s6_region_r;

  assign tail = s1_t_r > T_W'(s1_a_r);
  assign u    = {s1_t_r, 1'b0} - U_W'(s1_a_r);
  always_comb begin
    if (tail) begin
      region_nxt = s1_left_r ? REGION_LEFT : REGION_RIGHT;
    end else begin
      region_nxt = REGION_CORE;
    end
  end

  // stage 3: exponent magnitude m
  logic [SQ_W-1:0] prod3;
  logic [MF_W-1:0] mfull;
  logic [M_W-1:0]  s3_m_r, s4_m_r;
  logic            s3_zero_r, s4_zero_r, s5_zero_r, s6_zero_r;
  assign prod3 = SQ_W'(s2_opa_r) * SQ_W'(s2_opb_r);
  assign mfull = prod3[SQ_W-1:FRAC_BITS+1];

  // stage 4: n estimate
  logic [NP_W-1:0] prod4;
  logic [N_W-1:0]  s4_n_r, s5_n_r, s6_n_r;
  assign prod4 = NP_W'(s3_m_r) * NP_W'(N_RECIP);

  // stage 5: remainder estimate
  localparam int RD_W = N_W + R_W;
  logic [RD_W-1:0] rdiff;
  logic [R_W:0]    s5_r_r;
  assign rdiff = RD_W'({s4_m_r, EXP_SHIFT'(0)}) - RD_W'(s4_n_r) * RD_W'(LN2_Q30);

  // stage 6: one-step correction
  logic [R_W-1:0] s6_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    s0_mag_r  <= mag_full[MAG_W-1:0];
    s0_inv_r  <= left_nxt ? inv_left_r : inv_right_r;
    s0_a_r    <= left_nxt ? tail_left_r : tail_right_r;
    s0_left_r <= left_nxt;

    s1_t_r    <= prod1[FRAC_BITS +: T_W];
    s1_a_r    <= s0_a_r;
    s1_left_r <= s0_left_r;

    s2_opa_r    <= tail ? s1_a_r : s1_t_r[OPA_W-1:0];
    s2_opb_r    <= tail ? u : U_W'(s1_t_r);
    s2_sat_r    <= !tail && (|s1_t_r[T_W-1:CORE_T_BITS]);
    s2_region_r <= region_nxt;

    s3_m_r      <= mfull[M_W-1:0];
    s3_zero_r   <= s2_sat_r || (|mfull[MF_W-1:M_W]);
    s3_region_r <= s2_region_r;

    s4_m_r      <= s3_m_r;
    s4_n_r      <= prod4[N_RECIP_SHIFT +: N_W];
    s4_zero_r   <= s3_zero_r;
    s4_region_r <= s3_region_r;

    s5_r_r      <= rdiff[R_W:0];
    s5_n_r      <= s4_n_r;
    s5_zero_r   <= s4_zero_r;
    s5_region_r <= s4_region_r;

    if (s5_r_r >= (R_W+1)'(LN2_Q30)) begin
      s6_r_r <= R_W'(s5_r_r - (R_W+1)'(LN2_Q30));
      s6_n_r <= s5_n_r + N_W'(1);
    end else begin
      s6_r_r <= s5_r_r[R_W-1:0];
      s6_n_r <= s5_n_r;
    end
    s6_zero_r   <= s5_zero_r;
    s6_region_r <= s5_region_r;
  end

  // series: 12 terms, k = 12 down to 1
  logic      term_vld [SERIES_TERMS+1];
  egd_term_t term     [SERIES_TERMS+1];

  assign term_vld[0]    = vld_r[6];
  assign term[0].r      = s6_r_r;
  assign term[0].n      = s6_n_r;
  assign term[0].zero   = s6_zero_r;
  assign term[0].region = s6_region_r;
  assign term[0].acc    = ONE_Q30;

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    egd_horner_step #(
      .DIVISOR(SERIES_TERMS - i)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (term_vld[i]),
      .term_in (term[i]),
      .vld_out (term_vld[i+1]),
      .term_out(term[i+1])
    );
  end

  // output: round and scale by 2^-(n + EXP_SHIFT)
  egd_term_t       fin;
  logic [5:0]      shamt;
  logic [32:0]     rounded;
  logic [32:0]     scaled;
  logic [DENS_W-1:0] dens_nxt;
  logic              strobe_r;
  logic [DENS_W-1:0] density_r;
  logic [REGION_W-1:0] region_r;

  assign fin = term[SERIES_TERMS];

  always_comb begin
    shamt   = 6'(fin.n) + 6'(EXP_SHIFT);
    rounded = 33'(fin.acc) + (33'd1 << (shamt - 6'd1));
    scaled  = rounded >> shamt;
    if (fin.zero || (fin.n > N_MAX_SHIFT)) begin
      dens_nxt = '0;
    end else if (|scaled[32:DENS_W]) begin
      dens_nxt = '1;
    end else begin
      dens_nxt = scaled[DENS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= term_vld[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    density_r <= dens_nxt;
    region_r  <= fin.region;
  end

  assign out_strobe  = strobe_r;
  assign out_density = density_r;
  assign out_region  = region_r;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_acc, LATENCY))
    else $error("result without a matching transaction");

  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_density <= (DENS_W'(1) << FRAC_BITS)))
    else $error("density above 1.0");

  a_zero_core: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && s3_zero_r && (s3_region_r == REGION_CORE)) |=> !$past(s2_sat_r, 2)
      || s4_zero_r)
    else $error("core saturation lost");

endmodule
